FILE: sv/esft_pkg.sv
// Shared types and constants for the endstop seek fine tune block.
// Used by esft_lane, esft_merge and endstop_seek_fine_tune_top; depends on nothing.
package esft_pkg;

	localparam int MOTORS = 4;
	localparam int CNT_W  = 32;
	localparam int DEB_W  = 8;

	localparam logic [DEB_W-1:0] DEB_MAX = {DEB_W{1'b1}};

	// Item kinds.
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_SUCCESS = 2'd1;
	localparam logic [1:0] ST_ERROR   = 2'd2;

	// Configuration register indices.
	localparam logic [2:0] CFG_TARGET_STEPS    = 3'd0;
	localparam logic [2:0] CFG_DEBOUNCE_LIMIT  = 3'd1;
	localparam logic [2:0] CFG_MOTOR_COUNT     = 3'd2;
	localparam logic [2:0] CFG_EXPECTED_LEVELS = 3'd3;
	localparam logic [2:0] CFG_DIR_INVERT_MASK = 3'd4;

	typedef logic [MOTORS-1:0] mask_t;

	// What one motor lane found on a tick.
	typedef struct packed {
		logic             fin;    // this lane would end the seek
		logic             err;    // ending is a step count overrun
		logic [CNT_W-1:0] steps;  // step count before this tick
	} lane_res_t;

	// What the merge stage decided for the whole tick.
	typedef struct packed {
		mask_t            apply;  // lanes whose counter updates are committed
		logic             stop;   // the seek ends on this tick
		logic [1:0]       status;
		logic [CNT_W-1:0] found;
	} merge_res_t;

endpackage

FILE: sv/endstop_seek_fine_tune_top.sv
// Top level of the endstop seek fine tune block: state, lanes, merge and output word.
// Depends on esft_pkg, esft_lane and esft_merge.
//
// Usage. The block steps up to four motors toward their endstops. Each input word
// (in_valid/in_ready) carries a kind (start seek, tick or force stop), the sampled
// endstop levels and, for a start, the direction levels to save. Every accepted
// word produces exactly one output word (out_valid/out_ready) carrying the step
// and direction pin levels, the running flag, a status and the found step count.
// The result of an accepted word is registered and shown from the next cycle.
// Throughput is one word per cycle while the receiver does not stall; all motors
// are evaluated together by four parallel lanes and a priority merge, so the rate
// is set by the single state update per word. The output register is refilled in
// the same cycle that its word is taken, so a stalled receiver only holds off the
// input side while the output register is full. The configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and must only be
// written while no word is in flight. Reset clears all counters, drive levels and
// the busy flag, loads the register defaults and empties the output register.
module endstop_seek_fine_tune_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  endstop_levels,
	input  logic [3:0]  current_dirs,
	// Output channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  step_levels,
	output logic [3:0]  dir_levels,
	output logic        running,
	output logic [1:0]  status,
	output logic [31:0] found_steps,
	// Configuration channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int M = esft_pkg::MOTORS;

	// Configuration registers.
	logic [esft_pkg::CNT_W-1:0] step_limit_q;
	logic [esft_pkg::DEB_W-1:0] debounce_limit_q;
	logic [2:0]                 motor_count_q;
	esft_pkg::mask_t            expected_levels_q;
	esft_pkg::mask_t            dir_invert_mask_q;

	// Seek state.
	logic [esft_pkg::CNT_W-1:0] step_cnt_q [M];
	logic [esft_pkg::DEB_W-1:0] deb_cnt_q  [M];
	esft_pkg::mask_t            saved_dirs_q;
	esft_pkg::mask_t            dir_drive_q;
	esft_pkg::mask_t            step_drive_q;
	logic                       busy_q;

	// Next state.
	logic [esft_pkg::CNT_W-1:0] step_cnt_nx [M];
	logic [esft_pkg::DEB_W-1:0] deb_cnt_nx  [M];
	esft_pkg::mask_t            saved_dirs_nx;
	esft_pkg::mask_t            dir_drive_nx;
	esft_pkg::mask_t            step_drive_nx;
	logic                       busy_nx;
	logic [1:0]                 status_nx;
	logic [esft_pkg::CNT_W-1:0] found_nx;

	// Lane signals.
	esft_pkg::mask_t            act_mask;
	esft_pkg::mask_t            off_mask;
	esft_pkg::mask_t            lane_toggle;
	esft_pkg::lane_res_t        lane_res   [M];
	logic [esft_pkg::CNT_W-1:0] lane_cnt_nx [M];
	logic [esft_pkg::DEB_W-1:0] lane_deb_nx [M];
	esft_pkg::merge_res_t       merge_res;

	logic in_fire;

	assign cfg_ready = 1'b1;
	// The output register can take a new word whenever it is empty or being emptied.
	assign in_ready  = !out_valid || out_ready;
	assign in_fire   = in_valid && in_ready;

	// Motors at or above the motor count are disabled; counts above the lane
	// number simply enable every lane.
	always_comb begin
		for (int i = 0; i < M; i++) begin
			act_mask[i] = (motor_count_q > 3'(i));
		end
		off_mask = (endstop_levels ^ expected_levels_q) & act_mask;
	end

	for (genvar g = 0; g < M; g++) begin : g_lane
		esft_lane u_lane (
			.en            (act_mask[g]),
			.off           (off_mask[g]),
			.cnt           (step_cnt_q[g]),
			.deb           (deb_cnt_q[g]),
			.step_limit    (step_limit_q),
			.debounce_limit(debounce_limit_q),
			.res           (lane_res[g]),
			.cnt_nx        (lane_cnt_nx[g]),
			.deb_nx        (lane_deb_nx[g]),
			.toggle        (lane_toggle[g])
		);
	end

	esft_merge u_merge (
		.en (act_mask),
		.res(lane_res),
		.mr (merge_res)
	);

	// Next-state logic for one accepted word.
	always_comb begin
		step_cnt_nx   = step_cnt_q;
		deb_cnt_nx    = deb_cnt_q;
		saved_dirs_nx = saved_dirs_q;
		dir_drive_nx  = dir_drive_q;
		step_drive_nx = step_drive_q;
		busy_nx       = busy_q;
		status_nx     = esft_pkg::ST_NONE;
		found_nx      = '0;
		case (kind)
			esft_pkg::KIND_START: begin
				busy_nx = 1'b0;
				if (off_mask != '0) begin
					// An endstop is already off level: nothing to seek.
					status_nx = esft_pkg::ST_SUCCESS;
				end else begin
					saved_dirs_nx = (saved_dirs_q & ~act_mask) | (current_dirs & act_mask);
					dir_drive_nx  = (dir_drive_q & ~act_mask) | (~dir_invert_mask_q & act_mask);
					for (int i = 0; i < M; i++) begin
						if (act_mask[i]) begin
							step_cnt_nx[i] = '0;
							deb_cnt_nx[i]  = '0;
						end
					end
					busy_nx = 1'b1;
				end
			end
			esft_pkg::KIND_TICK: begin
				if (busy_q) begin
					for (int i = 0; i < M; i++) begin
						if (merge_res.apply[i]) begin
							step_cnt_nx[i]   = lane_cnt_nx[i];
							deb_cnt_nx[i]    = lane_deb_nx[i];
							step_drive_nx[i] = step_drive_q[i] ^ lane_toggle[i];
						end
					end
					status_nx = merge_res.status;
					found_nx  = merge_res.found;
					if (merge_res.stop) begin
						dir_drive_nx = (dir_drive_q & ~act_mask) | (saved_dirs_q & act_mask);
						busy_nx      = 1'b0;
					end
				end
			end
			esft_pkg::KIND_STOP: begin
				dir_drive_nx = (dir_drive_q & ~act_mask) | (saved_dirs_q & act_mask);
				busy_nx      = 1'b0;
			end
			default: begin
				// The unused kind changes nothing and reports the current levels.
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q      <= esft_pkg::CNT_W'(1);
			debounce_limit_q  <= esft_pkg::DEB_W'(1);
			motor_count_q     <= '0;
			expected_levels_q <= '0;
			dir_invert_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				esft_pkg::CFG_TARGET_STEPS:    step_limit_q      <= cfg_data;
				esft_pkg::CFG_DEBOUNCE_LIMIT:  debounce_limit_q  <= cfg_data[esft_pkg::DEB_W-1:0];
				esft_pkg::CFG_MOTOR_COUNT:     motor_count_q     <= cfg_data[2:0];
				esft_pkg::CFG_EXPECTED_LEVELS: expected_levels_q <= cfg_data[M-1:0];
				esft_pkg::CFG_DIR_INVERT_MASK: dir_invert_mask_q <= cfg_data[M-1:0];
				default: begin
				end
			endcase
		end
	end

	// Seek state, committed when a word is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < M; i++) begin
				step_cnt_q[i] <= '0;
				deb_cnt_q[i]  <= '0;
			end
			saved_dirs_q <= '0;
			dir_drive_q  <= '0;
			step_drive_q <= '0;
			busy_q       <= 1'b0;
		end else if (in_fire) begin
			step_cnt_q   <= step_cnt_nx;
			deb_cnt_q    <= deb_cnt_nx;
			saved_dirs_q <= saved_dirs_nx;
			dir_drive_q  <= dir_drive_nx;
			step_drive_q <= step_drive_nx;
			busy_q       <= busy_nx;
		end
	end

	// Output register: the valid flag is control state, the word is payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			step_levels <= step_drive_nx;
			dir_levels  <= dir_drive_nx;
			running     <= busy_nx;
			status      <= status_nx;
			found_steps <= found_nx;
		end
	end

endmodule

FILE: sv/esft_lane.sv
// One motor lane of the endstop seek: error check, step and debounce update.
// Depends on esft_pkg.
module esft_lane (
	input  logic                      en,
	input  logic                      off,
	input  logic [esft_pkg::CNT_W-1:0] cnt,
	input  logic [esft_pkg::DEB_W-1:0] deb,
	input  logic [esft_pkg::CNT_W-1:0] step_limit,
	input  logic [esft_pkg::DEB_W-1:0] debounce_limit,
	output esft_pkg::lane_res_t        res,
	output logic [esft_pkg::CNT_W-1:0] cnt_nx,
	output logic [esft_pkg::DEB_W-1:0] deb_nx,
	output logic                      toggle
);

	logic                       err;
	logic [esft_pkg::DEB_W-1:0] deb_inc;
	logic                       hit;

	always_comb begin
		err     = (cnt >= step_limit);
		deb_inc = (deb == esft_pkg::DEB_MAX) ? deb : deb + 1'b1;
		hit     = !err && off && (deb_inc >= debounce_limit);

		res.fin   = en && (err || hit);
		res.err   = err;
		res.steps = cnt;

		// An at-level motor steps and clears its debounce; otherwise it debounces.
		toggle = !off;
		cnt_nx = off ? cnt : cnt + 1'b1;
		deb_nx = off ? deb_inc : '0;
	end

endmodule

FILE: sv/esft_merge.sv
// Priority merge of the motor lanes: the lowest finishing lane ends the tick.
// Depends on esft_pkg.
module esft_merge (
	input  esft_pkg::mask_t     en,
	input  esft_pkg::lane_res_t res [esft_pkg::MOTORS],
	output esft_pkg::merge_res_t mr
);

	logic blocked;

	always_comb begin
		blocked   = 1'b0;
		mr.apply  = '0;
		mr.stop   = 1'b0;
		mr.status = esft_pkg::ST_NONE;
		mr.found  = '0;
		for (int i = 0; i < esft_pkg::MOTORS; i++) begin
			if (en[i] && !blocked) begin
				if (res[i].fin) begin
					blocked = 1'b1;
					mr.stop = 1'b1;
					if (res[i].err) begin
						mr.status = esft_pkg::ST_ERROR;
					end else begin
						// The confirming lane still commits its debounce update.
						mr.apply[i] = 1'b1;
						mr.status   = esft_pkg::ST_SUCCESS;
						mr.found    = res[i].steps;
					end
				end else begin
					mr.apply[i] = 1'b1;
				end
			end
		end
	end

endmodule
